// ----- design/rqsr_pkg.sv -----
// Package for the ring queue with swap and rotate operations.
// Holds command and result beat types, operation codes and cell select codes.
// Has no dependencies.
package rqsr_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    KIND_ENQ    = 2'd0,
    KIND_DEQ    = 2'd1,
    KIND_SWAP   = 2'd2,
    KIND_ROTATE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // What a cell loads on the next clock edge.
  typedef enum logic [2:0] {
    SEL_HOLD  = 3'd0,
    SEL_PUSH  = 3'd1,
    SEL_NEXT  = 3'd2,
    SEL_PREV  = 3'd3,
    SEL_FRONT = 3'd4
  } cell_sel_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [DataW-1:0]  push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0]  popped_value;
    status_e                  status;
    logic        [CountW-1:0] entry_count;
    logic signed [DataW-1:0]  front_value;
    logic signed [DataW-1:0]  back_value;
    logic signed [DataW-1:0]  second_value;
  } res_t;

endpackage

// ----- design/rqsr_cell.sv -----
// One storage cell of the queue chain: holds a single entry.
// Depends on rqsr_pkg for the data width and the select codes.
module rqsr_cell (
  input  logic                               clk_i,
  input  rqsr_pkg::cell_sel_e                sel_i,
  input  logic signed [rqsr_pkg::DataW-1:0]  push_i,
  input  logic signed [rqsr_pkg::DataW-1:0]  next_i,
  input  logic signed [rqsr_pkg::DataW-1:0]  prev_i,
  input  logic signed [rqsr_pkg::DataW-1:0]  front_i,
  output logic signed [rqsr_pkg::DataW-1:0]  value_o,
  output logic signed [rqsr_pkg::DataW-1:0]  value_d_o
);
  import rqsr_pkg::*;

  logic signed [DataW-1:0] value_q;
  logic signed [DataW-1:0] value_d;

  always_comb begin
    unique case (sel_i)
      SEL_HOLD:  value_d = value_q;
      SEL_PUSH:  value_d = push_i;
      SEL_NEXT:  value_d = next_i;
      SEL_PREV:  value_d = prev_i;
      SEL_FRONT: value_d = front_i;
      default:   value_d = value_q;
    endcase
  end

  // Entry contents need no reset; the fill count decides what is live.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o   = value_q;
  assign value_d_o = value_d;

endmodule

// ----- design/ring_queue_with_swap_rotate_core.sv -----
// Ring queue core with enqueue, dequeue, swap-front and rotate commands.
// Built from a row of rqsr_cell instances; types and codes come from rqsr_pkg.
// The result beat is registered and appears in the cycle after the command beat is taken.
// Throughput: one command per cycle; busy stays low, and the receiver cannot stall.
// Reset clears the entry count and the result strobe; entry contents are
// undefined until written and are never shown before they are written.
module ring_queue_with_swap_rotate_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rqsr_pkg::cmd_t  cmd_i,
  output logic            valid_o,
  output rqsr_pkg::res_t  res_o
);
  import rqsr_pkg::*;

  // The queue is kept in order in a row of cells: cell 0 is always the head,
  // cell count-1 the tail. Bar rotate's head-to-tail copy, each command moves data
  // one cell at most, so a software queue's ring pointers become plain shifts here.
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]          count_q, count_d;
  logic signed [DataW-1:0]  back_q, back_d;
  logic                     valid_q;
  res_t                     res_q, res_d;

  logic signed [DataW-1:0]  cell_q [DEPTH];
  logic signed [DataW-1:0]  cell_d [DEPTH];
  cell_sel_e                sel    [DEPTH];

  logic is_empty, is_full, has_two, take;

  assign take     = start & ~busy;
  assign busy     = 1'b0;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(DEPTH));
  assign has_two  = (count_q >= CntW'(2));

  // Per-cell select: each cell compares its own position with the count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] next_v, prev_v;

    if (i == DEPTH - 1) begin : g_last
      assign next_v = cell_q[i];
    end else begin : g_mid
      assign next_v = cell_q[i+1];
    end
    if (i == 0) begin : g_first
      assign prev_v = cell_q[i];
    end else begin : g_rest
      assign prev_v = cell_q[i-1];
    end

    always_comb begin
      sel[i] = SEL_HOLD;
      if (take) begin
        unique case (cmd_i.kind)
          KIND_ENQ: begin
            if (!is_full && count_q == CntW'(i)) sel[i] = SEL_PUSH;
          end
          KIND_DEQ: begin
            if (!is_empty) sel[i] = SEL_NEXT;
          end
          KIND_SWAP: begin
            if (has_two && i == 0) sel[i] = SEL_NEXT;
            if (has_two && i == 1) sel[i] = SEL_PREV;
          end
          KIND_ROTATE: begin
            // The head moves to the tail cell; every entry behind it shifts toward the head.
            if (!is_empty) begin
              if (count_q == CntW'(i + 1)) begin
                sel[i] = SEL_FRONT;
              end else begin
                sel[i] = SEL_NEXT;
              end
            end
          end
          default: sel[i] = SEL_HOLD;
        endcase
      end
    end

    rqsr_cell u_cell (
      .clk_i     (clk_i),
      .sel_i     (sel[i]),
      .push_i    (cmd_i.push_value),
      .next_i    (next_v),
      .prev_i    (prev_v),
      .front_i   (cell_q[0]),
      .value_o   (cell_q[i]),
      .value_d_o (cell_d[i])
    );
  end

  // Count, tail copy and the result beat. The tail entry is tracked in its own
  // register so that it never has to be picked out of the row by position.
  always_comb begin
    count_d            = count_q;
    back_d             = back_q;
    res_d.popped_value = '0;
    res_d.status       = STATUS_OK;
    unique case (cmd_i.kind)
      KIND_ENQ: begin
        if (is_full) begin
          res_d.status = STATUS_FULL;
        end else begin
          count_d = count_q + CntW'(1);
          back_d  = cmd_i.push_value;
        end
      end
      KIND_DEQ: begin
        if (is_empty) begin
          res_d.status = STATUS_EMPTY;
        end else begin
          count_d            = count_q - CntW'(1);
          res_d.popped_value = cell_q[0];
        end
      end
      KIND_SWAP: begin
        // With exactly two entries the old head becomes the tail.
        if (count_q == CntW'(2)) back_d = cell_q[0];
      end
      KIND_ROTATE: begin
        if (!is_empty) back_d = cell_q[0];
      end
      default: count_d = count_q;
    endcase
    res_d.entry_count  = CountW'(count_d);
    res_d.front_value  = (count_d != '0) ? cell_d[0] : '0;
    res_d.back_value   = (count_d != '0) ? back_d : '0;
    res_d.second_value = (count_d >= CntW'(2)) ? cell_d[1] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= take;
      if (take) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      back_q <= back_d;
      res_q  <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for ring_queue_with_swap_rotate_core.
// Tracks the ring contents in a scoreboard class and checks each result beat.
// Depends on rqsr_pkg and the core module only.
`timescale 1ns / 1ps

module tb_top;
  import rqsr_pkg::*;

  localparam int unsigned QDepth      = 16;
  localparam int unsigned RandomOps   = 600;
  localparam int unsigned SteadyTail  = 150;  // last commands go without gaps
  localparam int unsigned QuietLimit  = 200;  // cycles with no beat before giving up

  // Keeps its own copy of the ring and the expected result beats, oldest first.
  class ring_queue_tracker;
    logic [DataW-1:0] slots [QDepth];
    int unsigned      head_idx;
    int unsigned      tail_idx;
    int unsigned      fill;
    res_t             awaited_results [$];
    int unsigned      mismatch_count;

    function int unsigned wrap_next(int unsigned idx);
      return (idx + 1 >= QDepth) ? 0 : idx + 1;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    // Applies one accepted command to the ring and queues the result it must produce.
    function void apply_operation(cmd_t c);
      res_t             r;
      logic [DataW-1:0] held;
      r = '0;
      case (c.kind)
        KIND_ENQ: begin
          if (fill >= QDepth) begin
            r.status = STATUS_FULL;
          end else begin
            slots[tail_idx] = c.push_value;
            tail_idx        = wrap_next(tail_idx);
            fill++;
          end
        end
        KIND_DEQ: begin
          if (fill == 0) begin
            r.status = STATUS_EMPTY;
          end else begin
            r.popped_value = slots[head_idx];
            head_idx       = wrap_next(head_idx);
            fill--;
          end
        end
        KIND_SWAP: begin
          if (fill >= 2) begin
            held                      = slots[head_idx];
            slots[head_idx]           = slots[wrap_next(head_idx)];
            slots[wrap_next(head_idx)] = held;
          end
        end
        default: begin
          // On a full ring head and tail coincide, so the copy is a no-op.
          if (fill != 0) begin
            slots[tail_idx] = slots[head_idx];
            head_idx        = wrap_next(head_idx);
            tail_idx        = wrap_next(tail_idx);
          end
        end
      endcase
      r.entry_count = fill[CountW-1:0];
      if (fill != 0) begin
        r.front_value = slots[head_idx];
        r.back_value  = slots[(tail_idx == 0) ? QDepth - 1 : tail_idx - 1];
      end
      if (fill >= 2) begin
        r.second_value = slots[wrap_next(head_idx)];
      end
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (got !== want) begin
        mismatch_count++;
        $display("%0t: %s expected 0x%08h actual 0x%08h", $time, field, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with none expected, actual %p", $time, got);
        return;
      end
      want = awaited_results.pop_front();
      compare_field("popped_value", want.popped_value, got.popped_value);
      compare_field("status", want.status, got.status);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("back_value", want.back_value, got.back_value);
      compare_field("second_value", want.second_value, got.second_value);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic valid_o;
  res_t res_o;

  ring_queue_tracker tracker = new();
  int unsigned       quiet_cycles;
  bit                gaps_on;

  always #10 clk_i = ~clk_i;

  ring_queue_with_swap_rotate_core #(
    .DEPTH(QDepth)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  // Inputs change only through nonblocking writes at the rising edge, so the values
  // read here are the ones the core sees at that same edge.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      tracker.apply_operation(cmd_i);
    end
    if (rst_ni && valid_o) begin
      tracker.check_result(res_o);
    end
    if (rst_ni && ((start && !busy) || valid_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  // Watchdog, sampled away from the rising edge.
  initial begin
    do @(negedge clk_i); while (quiet_cycles < QuietLimit);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic hold_off(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Sender waits until every expected result beat has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // Presents one command beat, waits for the edge that takes it, and with gaps on may then hold start low.
  task automatic issue_op(kind_e kind, logic [DataW-1:0] value);
    cmd_t c;
    c.kind       = kind;
    c.push_value = value;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      hold_off($urandom_range(1, 11));
    end
  endtask

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned mode_left;
    int unsigned mode;
    int unsigned roll;
    kind_e       kind;

    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    gaps_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-queue corners, one and two entries, then fill to the brim.
    issue_op(KIND_DEQ, 32'h1234_5678);
    issue_op(KIND_SWAP, 32'h0);
    issue_op(KIND_ROTATE, 32'h0);
    issue_op(KIND_ENQ, 32'h7fff_ffff);
    issue_op(KIND_SWAP, 32'h0);
    issue_op(KIND_ROTATE, 32'h0);
    issue_op(KIND_ENQ, 32'h8000_0000);
    issue_op(KIND_SWAP, 32'hffff_ffff);
    issue_op(KIND_ROTATE, 32'hffff_ffff);
    for (int i = 0; i < QDepth - 2; i++) begin
      issue_op(KIND_ENQ, i[0] ? ~(32'h1 << (2 * i)) : (32'h1 << (2 * i + 1)));
    end
    issue_op(KIND_ENQ, 32'h5555_aaaa);  // dropped, ring is full
    issue_op(KIND_ROTATE, 32'h0);
    issue_op(KIND_SWAP, 32'h0);
    drain_results();

    // Random part: bursts that lean toward filling, draining or an even mix, so the
    // ring keeps crossing both the full and the empty boundary.
    mode_left = 0;
    mode      = 0;
    for (int unsigned n = 0; n < RandomOps; n++) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 40);
      end
      mode_left--;
      roll = $urandom_range(0, 99);
      case (mode)
        0: kind = (roll < 65) ? KIND_ENQ : (roll < 80) ? KIND_DEQ :
                  (roll < 90) ? KIND_SWAP : KIND_ROTATE;
        1: kind = (roll < 65) ? KIND_DEQ : (roll < 80) ? KIND_ENQ :
                  (roll < 90) ? KIND_SWAP : KIND_ROTATE;
        default: kind = kind_e'($urandom_range(0, 3));
      endcase
      gaps_on = (n < RandomOps - SteadyTail);
      if (n == RandomOps / 2) begin
        drain_results();
      end
      issue_op(kind, pick_value());
    end

    drain_results();
    repeat (3) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
